[sv/wgpc_pkg.sv]
// Shared types and constants for the waypoint guidance controller.
package wgpc_pkg;

    // CORDIC datapath widths
    localparam int CW = 38;  // x, y working width
    localparam int ZW = 21;  // angle accumulator width
    localparam int MW = 37;  // magnitude width
    localparam int LB = 19;  // low slice of the magnitude multiply

    localparam logic [29:0] INV_K = 30'd652032874;  // 1/K in Q0.30

    localparam logic signed [ZW-1:0] Q_PI = 21'sd205887;

    // atan(2^-i) in Q16.16
    localparam logic signed [ZW-1:0] ATAN_TAB [32] = '{
        21'sd51472, 21'sd30386, 21'sd16055, 21'sd8150,
        21'sd4091,  21'sd2047,  21'sd1024,  21'sd512,
        21'sd256,   21'sd128,   21'sd64,    21'sd32,
        21'sd16,    21'sd8,     21'sd4,     21'sd2,
        21'sd1,     21'sd0,     21'sd0,     21'sd0,
        21'sd0,     21'sd0,     21'sd0,     21'sd0,
        21'sd0,     21'sd0,     21'sd0,     21'sd0,
        21'sd0,     21'sd0,     21'sd0,     21'sd0
    };

    // One vector in flight through the CORDIC chain
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zf;  // zero vector
    } t_crd;

endpackage

[sv/waypoint_guidance_p_control.sv]
// Top level: line-of-sight waypoint guidance with four proportional commands.
//
// Usage:
//   s_axis carries one pose/velocity sample per transaction; m_axis returns
//   one transaction of four saturated Q16.16 commands per sample, in order.
//   Goal, gains and cruise speed are written through the i_cfg_* port while
//   the block is idle; each write lands at the clock edge with i_cfg_we high.
//   Two CORDIC passes run in series, each CORDIC_STEPS + 3 stages deep.
//   Throughput is one sample per cycle while the skid buffer is empty: the
//   CORDIC chains are fully pipelined, with the heading and planar-speed
//   passes running side by side and then the pitch and 3-D speed passes.
//   An output register plus a one-entry skid buffer decouple the two sides.
//   When m_axis stalls, the skid fills and s_axis_tready drops, freezing the
//   pipeline in place until the receiver takes the waiting transaction.
//   Synchronous active-low reset clears all valid bits and loads the
//   register defaults (goal 0, gains 1.0, cruise speed 1.0).
module waypoint_guidance_p_control #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, pos_z, roll, pitch, heading, vel_x, vel_y, vel_z, pad
    input  logic [231:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // roll_cmd, pitch_cmd, heading_cmd, speed_cmd
    output logic [127:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata
);

    localparam int LV = CORDIC_STEPS + 3;
    localparam int CW = wgpc_pkg::CW;
    localparam int ZW = wgpc_pkg::ZW;
    localparam int MW = wgpc_pkg::MW;

    localparam logic [2:0] REG_GOAL_X   = 3'd0;
    localparam logic [2:0] REG_GOAL_Y   = 3'd1;
    localparam logic [2:0] REG_GOAL_Z   = 3'd2;
    localparam logic [2:0] REG_GAIN_R   = 3'd3;
    localparam logic [2:0] REG_GAIN_P   = 3'd4;
    localparam logic [2:0] REG_GAIN_H   = 3'd5;
    localparam logic [2:0] REG_GAIN_S   = 3'd6;
    localparam logic [2:0] REG_CRUISE   = 3'd7;

    // wrap to [-pi, pi]
    function automatic logic signed [18:0] wrap_ang(input logic signed [22:0] a);
        logic signed [22:0] b;
        b = a;
        if (b > 23'sd205887) b = b - 23'sd411775;
        if (b < -23'sd205887) b = b + 23'sd411775;
        if (b > 23'sd205887) b = b - 23'sd411775;
        if (b < -23'sd205887) b = b + 23'sd411775;
        return b[18:0];
    endfunction

    // round half up, shift by 16, saturate to 32 bits
    function automatic logic [31:0] sat_cmd(input logic signed [59:0] p);
        logic signed [59:0] r;
        r = (p + 60'sd32768) >>> 16;
        if (r > 60'sd2147483647) return 32'h7fff_ffff;
        if (r < -60'sd2147483648) return 32'h8000_0000;
        return r[31:0];
    endfunction

    // configuration registers
    logic signed [31:0] r_goal_x, r_goal_y, r_goal_z;
    logic signed [31:0] r_gain_r, r_gain_p, r_gain_h, r_gain_s;
    logic        [23:0] r_cruise;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x <= '0;
            r_goal_y <= '0;
            r_goal_z <= '0;
            r_gain_r <= 32'sd65536;
            r_gain_p <= 32'sd65536;
            r_gain_h <= 32'sd65536;
            r_gain_s <= 32'sd65536;
            r_cruise <= 24'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_GOAL_X: r_goal_x <= i_cfg_wdata;
                REG_GOAL_Y: r_goal_y <= i_cfg_wdata;
                REG_GOAL_Z: r_goal_z <= i_cfg_wdata;
                REG_GAIN_R: r_gain_r <= i_cfg_wdata;
                REG_GAIN_P: r_gain_p <= i_cfg_wdata;
                REG_GAIN_H: r_gain_h <= i_cfg_wdata;
                REG_GAIN_S: r_gain_s <= i_cfg_wdata;
                REG_CRUISE: r_cruise <= i_cfg_wdata[23:0];
                default:    r_cruise <= r_cruise;
            endcase
        end
    end

    // pipeline advance: frozen only while the skid holds a transaction
    logic en;
    logic r_skid_v;
    assign en = !r_skid_v;
    assign s_axis_tready = en;

    // input stage
    logic               r_v1;
    logic signed [31:0] r_px, r_py, r_pz;
    logic signed [18:0] r_roll, r_pitch, r_head;
    logic signed [24:0] r_vx, r_vy, r_vz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px    <= s_axis_tdata[31:0];
            r_py    <= s_axis_tdata[63:32];
            r_pz    <= s_axis_tdata[95:64];
            r_roll  <= s_axis_tdata[114:96];
            r_pitch <= s_axis_tdata[133:115];
            r_head  <= s_axis_tdata[152:134];
            r_vx    <= s_axis_tdata[177:153];
            r_vy    <= s_axis_tdata[202:178];
            r_vz    <= s_axis_tdata[227:203];
        end
    end

    // first CORDIC pass: heading to goal and planar speed
    logic signed [CW-1:0] dx, dy, ndz;
    logic signed [ZW-1:0] ang_a, ang_b, ang_c, ang_d;
    logic        [MW-1:0] mag_a, mag_b, mag_c, mag_d;

    assign dx  = CW'(r_goal_x) - CW'(r_px);
    assign dy  = CW'(r_goal_y) - CW'(r_py);
    assign ndz = CW'(r_pz) - CW'(r_goal_z);

    wgpc_vec #(.STEPS(CORDIC_STEPS)) u_vec_a (
        .i_clk (i_clk), .i_en (en), .i_x (dx), .i_y (dy),
        .o_ang (ang_a), .o_mag (mag_a)
    );

    wgpc_vec #(.STEPS(CORDIC_STEPS)) u_vec_c (
        .i_clk (i_clk), .i_en (en), .i_x (CW'(r_vx)), .i_y (CW'(r_vy)),
        .o_ang (ang_c), .o_mag (mag_c)
    );

    // side data riding along the first pass
    logic                 r_d1_v     [LV];
    logic signed [CW-1:0] r_d1_ndz   [LV];
    logic signed [18:0]   r_d1_roll  [LV];
    logic signed [18:0]   r_d1_pitch [LV];
    logic signed [18:0]   r_d1_head  [LV];
    logic signed [24:0]   r_d1_vz    [LV];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LV; k++) r_d1_v[k] <= 1'b0;
        end else if (en) begin
            r_d1_v[0] <= r_v1;
            for (int k = 1; k < LV; k++) r_d1_v[k] <= r_d1_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1_ndz[0]   <= ndz;
            r_d1_roll[0]  <= r_roll;
            r_d1_pitch[0] <= r_pitch;
            r_d1_head[0]  <= r_head;
            r_d1_vz[0]    <= r_vz;
            for (int k = 1; k < LV; k++) begin
                r_d1_ndz[k]   <= r_d1_ndz[k-1];
                r_d1_roll[k]  <= r_d1_roll[k-1];
                r_d1_pitch[k] <= r_d1_pitch[k-1];
                r_d1_head[k]  <= r_d1_head[k-1];
                r_d1_vz[k]    <= r_d1_vz[k-1];
            end
        end
    end

    // second CORDIC pass: pitch to goal and 3-D speed
    logic signed [18:0] eh;
    assign eh = wrap_ang(23'(ang_a) - 23'(r_d1_head[LV-1]));

    wgpc_vec #(.STEPS(CORDIC_STEPS)) u_vec_b (
        .i_clk (i_clk), .i_en (en), .i_x ({1'b0, mag_a}), .i_y (r_d1_ndz[LV-1]),
        .o_ang (ang_b), .o_mag (mag_b)
    );

    wgpc_vec #(.STEPS(CORDIC_STEPS)) u_vec_d (
        .i_clk (i_clk), .i_en (en), .i_x ({1'b0, mag_c}), .i_y (CW'(r_d1_vz[LV-1])),
        .o_ang (ang_d), .o_mag (mag_d)
    );

    // side data riding along the second pass
    logic               r_d2_v     [LV];
    logic signed [18:0] r_d2_roll  [LV];
    logic signed [18:0] r_d2_pitch [LV];
    logic signed [18:0] r_d2_eh    [LV];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LV; k++) r_d2_v[k] <= 1'b0;
        end else if (en) begin
            r_d2_v[0] <= r_d1_v[LV-1];
            for (int k = 1; k < LV; k++) r_d2_v[k] <= r_d2_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d2_roll[0]  <= r_d1_roll[LV-1];
            r_d2_pitch[0] <= r_d1_pitch[LV-1];
            r_d2_eh[0]    <= eh;
            for (int k = 1; k < LV; k++) begin
                r_d2_roll[k]  <= r_d2_roll[k-1];
                r_d2_pitch[k] <= r_d2_pitch[k-1];
                r_d2_eh[k]    <= r_d2_eh[k-1];
            end
        end
    end

    // error stage
    logic               r_e_v;
    logic signed [18:0] r_er, r_ep, r_eh;
    logic signed [27:0] r_es;
    logic signed [18:0] roll_w;

    assign roll_w = wrap_ang(23'(r_d2_roll[LV-1]));

    // multiply stage
    logic               r_m_v;
    logic signed [59:0] r_mr, r_mp, r_mh, r_ms;

    // round and saturate stage
    logic         r_p_v;
    logic [127:0] r_p_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
            r_m_v <= 1'b0;
            r_p_v <= 1'b0;
        end else if (en) begin
            r_e_v <= r_d2_v[LV-1];
            r_m_v <= r_e_v;
            r_p_v <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_er  <= -roll_w;
            r_ep  <= wrap_ang(23'(ang_b) - 23'(r_d2_pitch[LV-1]));
            r_eh  <= r_d2_eh[LV-1];
            r_es  <= $signed({4'b0, r_cruise}) - $signed({1'b0, mag_d[26:0]});
            r_mr  <= r_gain_r * r_er;
            r_mp  <= r_gain_p * r_ep;
            r_mh  <= r_gain_h * r_eh;
            r_ms  <= r_gain_s * r_es;
            r_p_d <= {sat_cmd(r_ms), sat_cmd(r_mh), sat_cmd(r_mp), sat_cmd(r_mr)};
        end
    end

    // output register and skid buffer
    logic         r_out_v;
    logic [127:0] r_out_d, r_skid_d;
    logic         push, pop;

    assign push = en && r_p_v;
    assign pop  = r_out_v && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (pop) begin
                r_skid_v <= 1'b0;
            end
        end else begin
            r_out_v <= push || (r_out_v && !pop);
            if (push && r_out_v && !pop) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (pop) r_out_d <= r_skid_d;
        end else if (push) begin
            if (!r_out_v || pop) r_out_d <= r_p_d;
            else                 r_skid_d <= r_p_d;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_d;

    // checks
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v) else $error("skid holds data with output empty");

    a_stall_holds_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && r_p_v) |=> r_p_v) else $error("pipeline tail lost while stalled");

    a_skid_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> !s_axis_tready) else $error("input accepted while skid full");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid) else $error("output valid after reset");

endmodule

[sv/wgpc_cell.sv]
// One vectoring CORDIC iteration, registered.
module wgpc_cell #(
    parameter int I = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  wgpc_pkg::t_crd i_d,
    output wgpc_pkg::t_crd o_d
);

    logic signed [wgpc_pkg::CW-1:0] x, y, sx, sy;
    logic signed [wgpc_pkg::ZW-1:0] z;
    wgpc_pkg::t_crd n_d, r_d;

    // rotate toward the x axis
    always_comb begin
        x  = i_d.x;
        y  = i_d.y;
        z  = i_d.z;
        sx = x >>> I;
        sy = y >>> I;
        n_d.zf = i_d.zf;
        if (y >= 0) begin
            n_d.x = x + sy;
            n_d.y = y - sx;
            n_d.z = z + wgpc_pkg::ATAN_TAB[I];
        end else begin
            n_d.x = x - sy;
            n_d.y = y + sx;
            n_d.z = z - wgpc_pkg::ATAN_TAB[I];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

[sv/wgpc_vec.sv]
// Vectoring CORDIC: pre-rotation, chain of cells, gain-corrected magnitude.
module wgpc_vec #(
    parameter int STEPS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [wgpc_pkg::CW-1:0] i_x,
    input  logic signed [wgpc_pkg::CW-1:0] i_y,
    output logic signed [wgpc_pkg::ZW-1:0] o_ang,
    output logic        [wgpc_pkg::MW-1:0] o_mag
);

    localparam int HB = wgpc_pkg::MW - wgpc_pkg::LB;

    wgpc_pkg::t_crd n_pre, r_pre;
    wgpc_pkg::t_crd w [STEPS+1];

    logic        [wgpc_pkg::MW-1:0]     xc;
    logic        [wgpc_pkg::LB+29:0]    r_pl;
    logic        [HB+29:0]              r_ph;
    logic signed [wgpc_pkg::ZW-1:0]     r_z1, r_z2;
    logic        [wgpc_pkg::MW+29:0]    sum;
    logic        [wgpc_pkg::MW-1:0]     r_mag;

    // left half plane: turn by pi first
    always_comb begin
        n_pre.zf = (i_x == '0) && (i_y == '0);
        n_pre.x  = i_x;
        n_pre.y  = i_y;
        n_pre.z  = '0;
        if (i_x < 0) begin
            n_pre.x = -i_x;
            n_pre.y = -i_y;
            n_pre.z = (i_y >= 0) ? wgpc_pkg::Q_PI : -wgpc_pkg::Q_PI;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pre <= n_pre;
        end
    end

    assign w[0] = r_pre;

    // iteration cells
    for (genvar g = 0; g < STEPS; g++) begin : g_cell
        wgpc_cell #(.I(g)) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_d   (w[g]),
            .o_d   (w[g+1])
        );
    end

    // magnitude: x * 1/K split into two partial products
    assign xc = (w[STEPS].x < 0) ? '0 : w[STEPS].x[wgpc_pkg::MW-1:0];
    assign sum = {r_ph, {wgpc_pkg::LB{1'b0}}} + (wgpc_pkg::MW+30)'(r_pl)
               + (wgpc_pkg::MW+30)'(1 << 29);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl  <= xc[wgpc_pkg::LB-1:0] * wgpc_pkg::INV_K;
            r_ph  <= xc[wgpc_pkg::MW-1:wgpc_pkg::LB] * wgpc_pkg::INV_K;
            r_z1  <= w[STEPS].zf ? '0 : w[STEPS].z;
            r_z2  <= r_z1;
            r_mag <= sum[wgpc_pkg::MW+29:30];
        end
    end

    assign o_ang = r_z2;
    assign o_mag = r_mag;

endmodule

[test/testbench.sv]
// Self-checking testbench for the waypoint guidance proportional controller.
`timescale 1ns / 1ps

module testbench;

    localparam int STEPS   = 16;
    localparam int LATENCY = 2 * STEPS + 11;
    localparam longint PI_Q     = 205887;
    localparam longint TWO_PI_Q = 411775;

    // Register indexes
    typedef enum logic [2:0] {
        REG_GOAL_X       = 3'd0,
        REG_GOAL_Y       = 3'd1,
        REG_GOAL_Z       = 3'd2,
        REG_GAIN_ROLL    = 3'd3,
        REG_GAIN_PITCH   = 3'd4,
        REG_GAIN_HEADING = 3'd5,
        REG_GAIN_SPEED   = 3'd6,
        REG_CRUISE       = 3'd7
    } t_reg_index;

    typedef struct packed {
        logic signed [24:0] vel_z;
        logic signed [24:0] vel_y;
        logic signed [24:0] vel_x;
        logic signed [18:0] heading;
        logic signed [18:0] pitch;
        logic signed [18:0] roll;
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } t_pose;

    typedef struct packed {
        logic signed [31:0] speed_cmd;
        logic signed [31:0] heading_cmd;
        logic signed [31:0] pitch_cmd;
        logic signed [31:0] roll_cmd;
    } t_cmds;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // pos_x, pos_y, pos_z, roll, pitch, heading, vel_x, vel_y, vel_z, pad
    logic [231:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // roll_cmd, pitch_cmd, heading_cmd, speed_cmd
    logic [127:0] m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_addr = '0;
    logic [31:0]  i_cfg_wdata = '0;

    waypoint_guidance_p_control #(.CORDIC_STEPS(STEPS)) u_dut (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Shadow copy of the register file
    longint goal_x, goal_y, goal_z;
    longint gain_roll, gain_pitch, gain_heading, gain_speed, cruise;

    t_cmds  cmd_queue[$];
    int     errors = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;

    longint atan_q[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                           256, 128, 64, 32, 16, 8, 4, 2, 1};

    // Vectoring CORDIC: angle and scaled magnitude of (x, y)
    task automatic cordic_vector(input longint x_in, input longint y_in,
                                 output longint angle, output longint mag);
        longint x, y, z, nx, ny;
        x = x_in;
        y = y_in;
        z = 0;
        if (x == 0 && y == 0) begin
            angle = 0;
            mag = 0;
            return;
        end
        if (x < 0) begin
            z = (y >= 0) ? PI_Q : -PI_Q;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++) begin
            // >>> on longint is a floor shift
            if (y >= 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += (i < 17) ? atan_q[i] : 0;
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= (i < 17) ? atan_q[i] : 0;
            end
            x = nx;
            y = ny;
        end
        angle = z;
        if (x < 0) x = 0;
        mag = longint'(((x * 64'd652032874) + (64'd1 << 29)) >> 30);
    endtask

    function automatic longint wrap_pi(input longint a);
        longint r;
        r = a;
        while (r > PI_Q) r -= TWO_PI_Q;
        while (r < -PI_Q) r += TWO_PI_Q;
        return r;
    endfunction

    // Gain times error, rounded half up, saturated to 32 bits
    function automatic logic [31:0] scale_sat(input longint gain, input longint err);
        longint p;
        p = (gain * err + 32768) >>> 16;
        if (p > 64'sd2147483647) p = 64'sd2147483647;
        if (p < -64'sd2147483648) p = -64'sd2147483648;
        return p[31:0];
    endfunction

    task automatic predict_commands(input t_pose s, output t_cmds c);
        longint dx, dy, dz, head_des, dxy, climb_ang, unused, vxy, speed;
        dx = goal_x - longint'(s.pos_x);
        dy = goal_y - longint'(s.pos_y);
        dz = goal_z - longint'(s.pos_z);
        cordic_vector(dx, dy, head_des, dxy);
        cordic_vector(dxy, -dz, climb_ang, unused);
        cordic_vector(longint'(s.vel_x), longint'(s.vel_y), unused, vxy);
        cordic_vector(vxy, longint'(s.vel_z), unused, speed);
        c.roll_cmd    = scale_sat(gain_roll, -wrap_pi(longint'(s.roll)));
        c.pitch_cmd   = scale_sat(gain_pitch, wrap_pi(climb_ang - longint'(s.pitch)));
        c.heading_cmd = scale_sat(gain_heading, wrap_pi(head_des - longint'(s.heading)));
        c.speed_cmd   = scale_sat(gain_speed, cruise - speed);
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_GOAL_X:       goal_x = longint'(signed'(val));
            REG_GOAL_Y:       goal_y = longint'(signed'(val));
            REG_GOAL_Z:       goal_z = longint'(signed'(val));
            REG_GAIN_ROLL:    gain_roll = longint'(signed'(val));
            REG_GAIN_PITCH:   gain_pitch = longint'(signed'(val));
            REG_GAIN_HEADING: gain_heading = longint'(signed'(val));
            REG_GAIN_SPEED:   gain_speed = longint'(signed'(val));
            REG_CRUISE:       cruise = longint'(val[23:0]);
            default: ;
        endcase
    endtask

    // Send one sample; prediction is queued at acceptance
    task automatic send_pose(input t_pose s);
        t_cmds c;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'h0, s};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_commands(s, c);
        cmd_queue.push_back(c);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (cmd_queue.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    function automatic t_pose random_pose(input bit near);
        t_pose s;
        logic [255:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom};
        s = raw[227:0];
        if (near) begin
            s.pos_x = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh007fffff;
            s.pos_y = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh007fffff;
            s.pos_z = $signed($urandom_range(0, 32'h003fffff)) - 32'sh001fffff;
            s.roll    = 19'($signed($urandom_range(0, 411774)) - 205887);
            s.pitch   = 19'($signed($urandom_range(0, 411774)) - 205887);
            s.heading = 19'($signed($urandom_range(0, 411774)) - 205887);
        end
        return s;
    endfunction

    // Directed corners: field extremes, zero vectors, axes, odd angles
    task automatic test_directed();
        t_pose s;
        s = '0;
        send_pose(s);
        s.pos_x = 32'sh7fffffff; s.pos_y = 32'sh80000000; s.pos_z = 32'sh7fffffff;
        s.vel_x = 25'h0ffffff; s.vel_y = 25'h1000000; s.vel_z = 25'h0ffffff;
        s.roll = 19'h3ffff; s.pitch = 19'h40000; s.heading = 19'h3ffff;
        send_pose(s);
        s = ~s;
        send_pose(s);
        s = '1;
        send_pose(s);
        s = '0; s.pos_x = -32'sd65536; s.roll = 19'sd205887; s.pitch = -19'sd205887;
        send_pose(s);
        s = '0; s.pos_x = 32'sd65536; s.pos_y = -32'sd1; s.heading = -19'sd205887;
        send_pose(s);
        s = '0; s.pos_x = 32'sd65536; s.heading = 19'sd205887;
        send_pose(s);
        s = '0; s.pos_z = 32'sd65536; s.vel_z = -25'sd65536;
        send_pose(s);
        s = '0; s.pos_z = -32'sd65536; s.vel_x = 25'sd3;
        send_pose(s);
        repeat (6) send_pose(random_pose(1'b0));
        drain();
    endtask

    task automatic test_random(input int count);
        repeat (count) send_pose(random_pose($urandom_range(3) != 0));
        drain();
    endtask

    task automatic test_config(input bit extreme);
        if (extreme) begin
            write_reg(REG_GOAL_X, 32'h7fffffff);
            write_reg(REG_GOAL_Y, 32'h80000000);
            write_reg(REG_GOAL_Z, 32'h7fffffff);
            write_reg(REG_GAIN_ROLL, 32'h80000000);
            write_reg(REG_GAIN_PITCH, 32'h7fffffff);
            write_reg(REG_GAIN_HEADING, 32'h80000000);
            write_reg(REG_GAIN_SPEED, 32'h7fffffff);
            write_reg(REG_CRUISE, 32'hffffffff);
        end else begin
            write_reg(REG_GOAL_X, $urandom_range(0, 32'h00ffffff) - 32'h007fffff);
            write_reg(REG_GOAL_Y, $urandom_range(0, 32'h00ffffff) - 32'h007fffff);
            write_reg(REG_GOAL_Z, $urandom_range(0, 32'h003fffff) - 32'h001fffff);
            write_reg(REG_GAIN_ROLL, $urandom_range(0, 32'h0007ffff) - 32'h0003ffff);
            write_reg(REG_GAIN_PITCH, $urandom_range(0, 32'h0007ffff) - 32'h0003ffff);
            write_reg(REG_GAIN_HEADING, $urandom);
            write_reg(REG_GAIN_SPEED, $urandom_range(0, 32'h0007ffff) - 32'h0003ffff);
            write_reg(REG_CRUISE, $urandom);
        end
    endtask

    // Receiver stalls
    always @(negedge i_clk) begin
        m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    // Compare each result transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_cmds got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (cmd_queue.size() == 0) begin
                $error("unexpected result transaction %h", m_axis_tdata);
                errors++;
            end else begin
                want = cmd_queue.pop_front();
                if (got.roll_cmd !== want.roll_cmd) begin
                    $error("roll_cmd exp %0d got %0d", want.roll_cmd, got.roll_cmd);
                    errors++;
                end
                if (got.pitch_cmd !== want.pitch_cmd) begin
                    $error("pitch_cmd exp %0d got %0d", want.pitch_cmd, got.pitch_cmd);
                    errors++;
                end
                if (got.heading_cmd !== want.heading_cmd) begin
                    $error("heading_cmd exp %0d got %0d", want.heading_cmd,
                           got.heading_cmd);
                    errors++;
                end
                if (got.speed_cmd !== want.speed_cmd) begin
                    $error("speed_cmd exp %0d got %0d", want.speed_cmd, got.speed_cmd);
                    errors++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("waypoint_guidance_p_control regression: fail");
        $finish;
    end

    initial begin
        goal_x = 0; goal_y = 0; goal_z = 0;
        gain_roll = 65536; gain_pitch = 65536; gain_heading = 65536;
        gain_speed = 65536; cruise = 65536;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random(60);
        test_config(1'b1);
        test_directed();
        test_random(40);

        test_config(1'b0);
        send_idle_pct = 72;
        test_random(80);
        test_config(1'b0);
        send_idle_pct = 0;
        recv_stall_pct = 72;
        test_random(80);
        test_config(1'b0);
        send_idle_pct = 15;
        recv_stall_pct = 15;
        test_random(80);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(30);

        if (errors == 0 && cmd_queue.size() == 0) begin
            $display("waypoint_guidance_p_control regression: pass");
        end else begin
            $display("waypoint_guidance_p_control regression: fail");
        end
        $finish;
    end

endmodule
